FILE: design/sha256_pkg.sv
package sha256_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] words8_t;
  typedef logic [15:0][31:0] sched_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_FINAL_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam int unsigned ROUNDS      = 64;
  localparam word_t       PAD_MARKER  = 32'h8000_0000;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;
  localparam logic [2:0]  LAST_INDEX  = 3'd7;

  // Word 0 sits in the lowest slice of the packed vector.
  localparam words8_t IV_SHA256 = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };
  localparam words8_t IV_SHA224 = {
    32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
    32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic words8_t initial_vector(input logic sel);
    return sel ? IV_SHA224 : IV_SHA256;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

FILE: design/sha256_in_if.sv
interface sha256_in_if;
  logic                 valid;
  logic                 ready;
  sha256_pkg::word_t    data_word;
  logic [2:0]           byte_count;
  logic                 final_word;

  modport source (output valid, data_word, byte_count, final_word, input ready);
  modport sink   (input valid, data_word, byte_count, final_word, output ready);
endinterface

FILE: design/sha256_out_if.sv
interface sha256_out_if;
  logic                 valid;
  logic                 ready;
  sha256_pkg::word_t    digest_word;
  logic [2:0]           word_index;
  logic                 last_result;

  modport source (output valid, digest_word, word_index, last_result, input ready);
  modport sink   (input valid, digest_word, word_index, last_result, output ready);
endinterface

FILE: design/sha256_round.sv
module sha256_round (
  input  sha256_pkg::words8_t work,
  input  sha256_pkg::word_t   round_k,
  input  sha256_pkg::sched_t  sched,
  output sha256_pkg::words8_t work_next,
  output sha256_pkg::word_t   sched_word
);

  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;

  // The oldest word of the schedule window feeds this round.
  assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + sha256_pkg::big_sigma1(work[4]) + ch + round_k + sched[0];
  assign t2  = sha256_pkg::big_sigma0(work[0]) + maj;

  assign work_next = {work[6], work[5], work[4], work[3] + t1,
                      work[2], work[1], work[0], t1 + t2};

  assign sched_word = sha256_pkg::small_sigma1(sched[14]) + sched[9]
                    + sha256_pkg::small_sigma0(sched[1]) + sched[0];

endmodule

FILE: design/sha256_message_digest_unit.sv
// Channel   Dir  Handshake          Payload
// in_chan   in   valid / ready      data_word[31:0], byte_count[2:0], final_word
// out_chan  out  valid / ready      digest_word[31:0], word_index[2:0], last_result
// cfg       in   cfg_we (no ready)  cfg_wdata: variant
//
// A non-final request only adds its word to the schedule window; every sixteenth word starts a block
// that occupies the shared round unit for all 64 rounds and then a chaining add.
// A final request adds the padding words and, per closing block, the rounds and chaining add,
// then eight result words, each held until the sink takes it.
// Reset is synchronous, active low, and loads the SHA-256 initial vector.
// in_chan.ready is high only while the sequencer is idle.
module sha256_message_digest_unit (
  input  logic                clk,
  input  logic                rst_n,
  sha256_in_if.sink           in_chan,
  sha256_out_if.source        out_chan,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  sha256_pkg::state_t   state_r, state_nxt;
  logic                 variant_r, variant_nxt;
  sha256_pkg::words8_t  chain_r, chain_nxt;
  sha256_pkg::words8_t  work_r, work_nxt;
  sha256_pkg::sched_t   sched_r, sched_nxt;
  logic [63:0]          bitlen_r, bitlen_nxt;
  logic [3:0]           fill_r, fill_nxt;
  logic [5:0]           round_r, round_nxt;
  logic [2:0]           idx_r, idx_nxt;
  logic                 fin_r, fin_nxt;
  logic                 mark_r, mark_nxt;
  logic                 hi_sent_r, hi_sent_nxt;
  logic                 len_done_r, len_done_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic                 push_en;
  logic                 push_wrap;
  sha256_pkg::word_t    push_word;
  sha256_pkg::word_t    first_word;
  sha256_pkg::word_t    pad_word;
  logic [2:0]           n_eff;
  sha256_pkg::words8_t  rnd_work;
  sha256_pkg::word_t    rnd_sched;

  sha256_round u_round (
    .work       (work_r),
    .round_k    (sha256_pkg::ROUND_K[round_r]),
    .sched      (sched_r),
    .work_next  (rnd_work),
    .sched_word (rnd_sched)
  );

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // A word without the final flag always counts as four bytes.
  assign n_eff = (!in_chan.final_word || (in_chan.byte_count > sha256_pkg::FULL_BYTES))
               ? sha256_pkg::FULL_BYTES : in_chan.byte_count;

  always_comb begin
    case (n_eff)
      3'd0:    first_word = sha256_pkg::PAD_MARKER;
      3'd1:    first_word = {in_chan.data_word[31:24], sha256_pkg::PAD_BYTE, 16'h0};
      3'd2:    first_word = {in_chan.data_word[31:16], sha256_pkg::PAD_BYTE, 8'h0};
      3'd3:    first_word = {in_chan.data_word[31:8], sha256_pkg::PAD_BYTE};
      default: first_word = in_chan.data_word;
    endcase
  end

  // The pad marker goes first if still owed, then zeros up to the length words.
  always_comb begin
    if (mark_r) begin
      pad_word = sha256_pkg::PAD_MARKER;
    end else if (fill_r == 4'd14) begin
      pad_word = bitlen_r[63:32];
    end else if (fill_r == 4'd15 && hi_sent_r) begin
      pad_word = bitlen_r[31:0];
    end else begin
      pad_word = '0;
    end
  end

  assign push_en   = in_acc || (state_r == sha256_pkg::ST_PAD);
  assign push_word = in_acc ? first_word : pad_word;
  assign push_wrap = push_en && (fill_r == 4'd15);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (push_wrap) begin
            state_nxt = sha256_pkg::ST_COMPRESS;
          end else if (in_chan.final_word) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (push_wrap) begin
          state_nxt = sha256_pkg::ST_COMPRESS;
        end
      end
      sha256_pkg::ST_COMPRESS: begin
        if (round_r == 6'(sha256_pkg::ROUNDS - 1)) begin
          state_nxt = sha256_pkg::ST_FINAL_ADD;
        end
      end
      sha256_pkg::ST_FINAL_ADD: begin
        if (len_done_r) begin
          state_nxt = sha256_pkg::ST_EMIT;
        end else if (fin_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_acc && idx_r == sha256_pkg::LAST_INDEX) begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_chan.ready  = (state_r == sha256_pkg::ST_IDLE);
    out_chan.valid = (state_r == sha256_pkg::ST_EMIT);
  end

  assign out_chan.digest_word = chain_r[idx_r];
  assign out_chan.word_index  = idx_r;
  assign out_chan.last_result = (idx_r == sha256_pkg::LAST_INDEX);

  // Datapath.
  always_comb begin
    variant_nxt  = variant_r;
    chain_nxt    = chain_r;
    work_nxt     = work_r;
    sched_nxt    = sched_r;
    bitlen_nxt   = bitlen_r;
    fill_nxt     = fill_r;
    round_nxt    = round_r;
    idx_nxt      = idx_r;
    fin_nxt      = fin_r;
    mark_nxt     = mark_r;
    hi_sent_nxt  = hi_sent_r;
    len_done_nxt = len_done_r;

    if (push_en) begin
      sched_nxt = {push_word, sched_r[15:1]};
      fill_nxt  = fill_r + 4'd1;
      if (push_wrap) begin
        work_nxt  = chain_r;
        round_nxt = '0;
      end
    end

    if (in_acc) begin
      bitlen_nxt = bitlen_r + {58'd0, n_eff, 3'd0};
      fin_nxt    = in_chan.final_word;
      mark_nxt   = in_chan.final_word && (n_eff == sha256_pkg::FULL_BYTES);
    end

    if (state_r == sha256_pkg::ST_PAD) begin
      if (mark_r) begin
        mark_nxt = 1'b0;
      end else if (fill_r == 4'd14) begin
        hi_sent_nxt = 1'b1;
      end else if (fill_r == 4'd15 && hi_sent_r) begin
        len_done_nxt = 1'b1;
      end
    end

    if (state_r == sha256_pkg::ST_COMPRESS) begin
      work_nxt  = rnd_work;
      sched_nxt = {rnd_sched, sched_r[15:1]};
      round_nxt = round_r + 6'd1;
    end

    if (state_r == sha256_pkg::ST_FINAL_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end

    // The last result taken starts a new message.
    if (out_acc) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == sha256_pkg::LAST_INDEX) begin
        chain_nxt    = sha256_pkg::initial_vector(variant_r);
        bitlen_nxt   = '0;
        fill_nxt     = '0;
        fin_nxt      = 1'b0;
        mark_nxt     = 1'b0;
        hi_sent_nxt  = 1'b0;
        len_done_nxt = 1'b0;
      end
    end

    if (cfg_we) begin
      variant_nxt  = cfg_wdata;
      chain_nxt    = sha256_pkg::initial_vector(cfg_wdata);
      bitlen_nxt   = '0;
      fill_nxt     = '0;
      fin_nxt      = 1'b0;
      mark_nxt     = 1'b0;
      hi_sent_nxt  = 1'b0;
      len_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256_pkg::ST_IDLE;
      variant_r  <= 1'b0;
      chain_r    <= sha256_pkg::IV_SHA256;
      bitlen_r   <= '0;
      fill_r     <= '0;
      round_r    <= '0;
      idx_r      <= '0;
      fin_r      <= 1'b0;
      mark_r     <= 1'b0;
      hi_sent_r  <= 1'b0;
      len_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      variant_r  <= variant_nxt;
      chain_r    <= chain_nxt;
      bitlen_r   <= bitlen_nxt;
      fill_r     <= fill_nxt;
      round_r    <= round_nxt;
      idx_r      <= idx_nxt;
      fin_r      <= fin_nxt;
      mark_r     <= mark_nxt;
      hi_sent_r  <= hi_sent_nxt;
      len_done_r <= len_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    sched_r <= sched_nxt;
  end

endmodule

FILE: design/sha256_checker.sv
module sha256_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       last_result
);

  // The block never takes a request while it is presenting a digest.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input ready while a digest word is offered");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_result == (word_index == 3'd7)))
    else $error("last_result does not match word_index");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_result) |=>
      (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words not delivered in order");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_result) |=> (!out_valid && in_ready))
    else $error("block not idle after the last digest word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
    else $error("stalled digest word changed");

endmodule

bind sha256_message_digest_unit sha256_checker u_sha256_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .word_index  (out_chan.word_index),
  .last_result (out_chan.last_result)
);
